>>> src/laft_pkg.sv
// Shared types, constants and helpers for the LMS adaptive FIR trainer.
// Used by laft_ctrl, laft_dp and lms_adaptive_fir_trainer; depends on nothing.
`default_nettype none

package laft_pkg;

  // Sizes of the stores
  localparam int MAX_TAPS  = 64;
  localparam int MAX_TRAIN = 4096;
  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int TAP_CW    = $clog2(MAX_TAPS + 1);
  localparam int ST_AW     = $clog2(MAX_TRAIN);
  localparam int ST_CW     = $clog2(MAX_TRAIN + 1);

  // Arithmetic widths
  localparam int SMP_W     = 16;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  localparam int PROD_W    = COEF_W + SMP_W;
  localparam int ACC_W     = PROD_W + TAP_AW;
  localparam int Y_W       = ACC_W - COEF_FRAC;
  localparam int MU_W      = 16;
  localparam int ERR_W     = SMP_W + 1;
  localparam int MUE_W     = MU_W + 1 + ERR_W;
  localparam int DLT_W     = MUE_W + SMP_W;
  localparam int DLT_SHIFT = 18;
  localparam int QUO_W     = 15;
  localparam int SCL_W     = SMP_W + QUO_W;
  localparam int STEP_CW   = $clog2(QUO_W);
  localparam int FULL_SCALE = 32767;

  // Configuration registers
  localparam int TAP_COUNT_W = 7;
  localparam int TRAIN_LEN_W = 13;
  localparam int STEP_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(32);
  localparam logic [TRAIN_LEN_W-1:0] TRAIN_LEN_RST = TRAIN_LEN_W'(4096);
  localparam logic [STEP_W-1:0]      STEP_RST      = STEP_W'(328);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 2'd0,
    REG_TRAIN_LEN = 2'd1,
    REG_STEP_SIZE = 2'd2
  } cfg_reg_e;

  // Item codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RUN    = 1'b1;
  localparam logic KIND_FILTER = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [SMP_W-1:0] desired;
    logic signed [SMP_W-1:0] reference;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic signed [SMP_W-1:0] filtered;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              in_latch;
    logic              load_we;
    logic [ST_AW-1:0]  des_addr;
    logic [ST_AW-1:0]  ref_addr;
    logic              scl_sel;
    logic              peak_clr;
    logic              peak_upd;
    logic              div_init;
    logic              div_step;
    logic              scl_we;
    logic [TAP_AW-1:0] coef_addr;
    logic              coef_we;
    logic [TAP_AW-1:0] ring_addr;
    logic              ring_we;
    logic              ring_clr;
    logic              mac_ring;
    logic              acc_clr;
    logic              mul_en;
    logic              acc_en;
    logic              err_en;
    logic              mue_en;
    logic              dlt_en;
    logic              out_load;
    logic              out_kind;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic peak_zero;
  } dp_stat_t;

  // Saturate the shifted accumulator to a sample
  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [Y_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[Y_W-1:SMP_W-1];
    hi_zeros = ~(|v[Y_W-1:SMP_W-1]);
    if (hi_ones || hi_zeros) begin
      sat16 = v[SMP_W-1:0];
    end else begin
      sat16 = v[Y_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
  endfunction

  // Saturate a coefficient sum to the coefficient width
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [COEF_W:0] v);
    if (v[COEF_W] == v[COEF_W-1]) begin
      sat32 = v[COEF_W-1:0];
    end else begin
      sat32 = v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> src/laft_dp.sv
// Datapath: training stores, coefficient and tap ring memories, shared MAC,
// scaling divider and output register. Depends on laft_pkg.
`default_nettype none

module laft_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire laft_pkg::dp_cmd_t                cmd_i,
  input  wire laft_pkg::in_item_t               in_item_i,
  input  wire logic [laft_pkg::STEP_W-1:0]      step_size_i,
  output laft_pkg::dp_stat_t                    stat_o,
  output laft_pkg::out_item_t                   out_item_o
);

  // Latched item samples
  logic signed [laft_pkg::SMP_W-1:0] in_des_q, in_ref_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      in_des_q <= in_item_i.desired;
      in_ref_q <= in_item_i.reference;
    end
  end

  // Training stores
  logic signed [laft_pkg::SMP_W-1:0] des_mem [laft_pkg::MAX_TRAIN];
  logic signed [laft_pkg::SMP_W-1:0] ref_mem [laft_pkg::MAX_TRAIN];
  logic signed [laft_pkg::SMP_W-1:0] des_rd_q, ref_rd_q;
  logic signed [laft_pkg::SMP_W-1:0] scl_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we || (cmd_i.scl_we && !cmd_i.scl_sel)) begin
      des_mem[cmd_i.des_addr] <= cmd_i.load_we ? in_des_q : scl_val;
    end
    if (cmd_i.load_we || (cmd_i.scl_we && cmd_i.scl_sel)) begin
      ref_mem[cmd_i.ref_addr] <= cmd_i.load_we ? in_ref_q : scl_val;
    end
    des_rd_q <= des_mem[cmd_i.des_addr];
    ref_rd_q <= ref_mem[cmd_i.ref_addr];
  end

  // Peak magnitude of the selected store
  logic signed [laft_pkg::SMP_W-1:0] sel_rd;
  logic [laft_pkg::SMP_W-1:0]        mag;
  logic [laft_pkg::SMP_W-1:0]        peak_q;

  assign sel_rd = cmd_i.scl_sel ? ref_rd_q : des_rd_q;
  assign mag    = sel_rd[laft_pkg::SMP_W-1] ? (~sel_rd + laft_pkg::SMP_W'(1)) : sel_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (cmd_i.peak_clr) begin
      peak_q <= '0;
    end else if (cmd_i.peak_upd && (mag > peak_q)) begin
      peak_q <= mag;
    end
  end

  assign stat_o.peak_zero = (peak_q == '0);

  // Restoring divider: |s| * 32767 / peak, one quotient bit a cycle
  logic [laft_pkg::SCL_W-1:0] scl_prod;
  logic [laft_pkg::SMP_W-1:0] rem_q, trial;
  logic [laft_pkg::QUO_W-1:0] lo_q, quo_q;
  logic                       neg_q, ge;
  logic signed [laft_pkg::SMP_W-1:0] quo_s;

  assign scl_prod = laft_pkg::SCL_W'(mag) * laft_pkg::SCL_W'(laft_pkg::FULL_SCALE);
  assign trial    = {rem_q[laft_pkg::SMP_W-2:0], lo_q[laft_pkg::QUO_W-1]};
  assign ge       = (trial >= peak_q);
  assign quo_s    = {1'b0, quo_q};
  assign scl_val  = neg_q ? -quo_s : quo_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= sel_rd[laft_pkg::SMP_W-1];
      rem_q <= laft_pkg::SMP_W'(scl_prod[laft_pkg::SCL_W-2:laft_pkg::QUO_W]);
      lo_q  <= scl_prod[laft_pkg::QUO_W-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (trial - peak_q) : trial;
      lo_q  <= {lo_q[laft_pkg::QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[laft_pkg::QUO_W-2:0], ge};
    end
  end

  // Coefficient memory; an entry never written reads as zero
  logic signed [laft_pkg::COEF_W-1:0] coef_mem [laft_pkg::MAX_TAPS];
  logic [laft_pkg::MAX_TAPS-1:0]      coef_vld_q;
  logic signed [laft_pkg::COEF_W-1:0] coef_rd_q, coef_eff, coef_new;
  logic                               coef_rdv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we) begin
      coef_mem[cmd_i.coef_addr] <= coef_new;
    end
    coef_rd_q <= coef_mem[cmd_i.coef_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      coef_rdv_q <= 1'b0;
    end else begin
      coef_rdv_q <= coef_vld_q[cmd_i.coef_addr];
      if (cmd_i.coef_we) begin
        coef_vld_q[cmd_i.coef_addr] <= 1'b1;
      end
    end
  end

  assign coef_eff = coef_rdv_q ? coef_rd_q : '0;

  // Tap ring; cleared through its valid bits
  logic signed [laft_pkg::SMP_W-1:0] ring_mem [laft_pkg::MAX_TAPS];
  logic [laft_pkg::MAX_TAPS-1:0]     ring_vld_q;
  logic signed [laft_pkg::SMP_W-1:0] ring_rd_q, ring_eff;
  logic                              ring_rdv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_we) begin
      ring_mem[cmd_i.ring_addr] <= in_ref_q;
    end
    ring_rd_q <= ring_mem[cmd_i.ring_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      ring_rdv_q <= 1'b0;
    end else begin
      ring_rdv_q <= ring_vld_q[cmd_i.ring_addr];
      if (cmd_i.ring_clr) begin
        ring_vld_q <= '0;
      end else if (cmd_i.ring_we) begin
        ring_vld_q[cmd_i.ring_addr] <= 1'b1;
      end
    end
  end

  assign ring_eff = ring_rdv_q ? ring_rd_q : '0;

  // Shared multiply-accumulate
  logic signed [laft_pkg::SMP_W-1:0]  mac_src;
  logic signed [laft_pkg::PROD_W-1:0] prod_q;
  logic signed [laft_pkg::ACC_W-1:0]  acc_q;
  logic signed [laft_pkg::SMP_W-1:0]  y;

  assign mac_src = cmd_i.mac_ring ? ring_eff : ref_rd_q;
  assign y       = laft_pkg::sat16(acc_q[laft_pkg::ACC_W-1:laft_pkg::COEF_FRAC]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= coef_eff * mac_src;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + laft_pkg::ACC_W'(prod_q);
    end
  end

  // Error, mu * error, and coefficient delta
  logic signed [laft_pkg::ERR_W-1:0] err_q;
  logic signed [laft_pkg::MUE_W-1:0] mue_q;
  logic signed [laft_pkg::DLT_W-1:0] dlt_q, dlt_sh;
  logic signed [laft_pkg::COEF_W:0]  coef_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_en) begin
      err_q <= laft_pkg::ERR_W'(des_rd_q) - laft_pkg::ERR_W'(y);
    end
    if (cmd_i.mue_en) begin
      mue_q <= $signed({1'b0, step_size_i}) * err_q;
    end
    if (cmd_i.dlt_en) begin
      dlt_q <= mue_q * ref_rd_q;
    end
  end

  assign dlt_sh   = dlt_q >>> laft_pkg::DLT_SHIFT;
  assign coef_sum = (laft_pkg::COEF_W+1)'(coef_eff) + (laft_pkg::COEF_W+1)'(dlt_sh);
  assign coef_new = laft_pkg::sat32(coef_sum);

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_o.kind     <= cmd_i.out_kind;
      out_item_o.filtered <= (cmd_i.out_kind == laft_pkg::KIND_DONE) ? '0 : y;
    end
  end

endmodule

`default_nettype wire

>>> src/laft_ctrl.sv
// Controller: sequencer for loading, scaling, LMS training and run items.
// Drives laft_dp through dp_cmd_t. Depends on laft_pkg.
`default_nettype none

module laft_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire laft_pkg::in_item_t                  in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  input  wire logic [laft_pkg::TAP_COUNT_W-1:0]    tap_count_i,
  input  wire logic [laft_pkg::TRAIN_LEN_W-1:0]    train_len_i,
  input  wire laft_pkg::dp_stat_t                  stat_i,
  output laft_pkg::dp_cmd_t                        cmd_o
);

  localparam int ST_N = 22;

  typedef enum logic [ST_N-1:0] {
    S_IDLE    = ST_N'(1) << 0,
    S_LOAD    = ST_N'(1) << 1,
    S_RUN     = ST_N'(1) << 2,
    S_MOD     = ST_N'(1) << 3,
    S_MAC_RD  = ST_N'(1) << 4,
    S_MAC_MUL = ST_N'(1) << 5,
    S_MAC_ACC = ST_N'(1) << 6,
    S_PK_RD   = ST_N'(1) << 7,
    S_PK_CMP  = ST_N'(1) << 8,
    S_PK_END  = ST_N'(1) << 9,
    S_SC_RD   = ST_N'(1) << 10,
    S_SC_MUL  = ST_N'(1) << 11,
    S_SC_DIV  = ST_N'(1) << 12,
    S_SC_WR   = ST_N'(1) << 13,
    S_TR_I    = ST_N'(1) << 14,
    S_ERR     = ST_N'(1) << 15,
    S_MUE     = ST_N'(1) << 16,
    S_UP_RD   = ST_N'(1) << 17,
    S_UP_MUL  = ST_N'(1) << 18,
    S_UP_WR   = ST_N'(1) << 19,
    S_FIN     = ST_N'(1) << 20,
    S_DONE    = ST_N'(1) << 21
  } state_e;

  state_e state_q, state_d;
  logic [laft_pkg::ST_CW-1:0]   i_q, i_d, load_cnt_q, load_cnt_d;
  logic [laft_pkg::TAP_CW-1:0]  k_q, k_d;
  logic [laft_pkg::STEP_CW-1:0] step_q, step_d;
  logic [laft_pkg::TAP_AW-1:0]  p_q, p_d, ridx_q, ridx_d, ptr_q, ptr_d;
  logic trained_q, trained_d, last_q, last_d, train_q, train_d;
  logic sel_q, sel_d, kind_q, kind_d, out_valid_q, out_valid_d;

  // Taps and length in use
  logic [laft_pkg::TAP_CW-1:0] taps;
  logic [laft_pkg::ST_CW-1:0]  len;
  logic [laft_pkg::TAP_CW-1:0] k_inc;
  logic [laft_pkg::TAP_AW-1:0] p_inc;

  always_comb begin
    if (tap_count_i == '0) begin
      taps = laft_pkg::TAP_CW'(1);
    end else if (laft_pkg::TAP_CW'(tap_count_i) > laft_pkg::TAP_CW'(laft_pkg::MAX_TAPS)) begin
      taps = laft_pkg::TAP_CW'(laft_pkg::MAX_TAPS);
    end else begin
      taps = laft_pkg::TAP_CW'(tap_count_i);
    end
    if (laft_pkg::ST_CW'(train_len_i) > laft_pkg::ST_CW'(laft_pkg::MAX_TRAIN)) begin
      len = laft_pkg::ST_CW'(laft_pkg::MAX_TRAIN);
    end else begin
      len = laft_pkg::ST_CW'(train_len_i);
    end
  end

  assign k_inc = k_q + laft_pkg::TAP_CW'(1);
  assign p_inc = p_q + laft_pkg::TAP_AW'(1);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    load_cnt_d  = load_cnt_q;
    k_d         = k_q;
    step_d      = step_q;
    p_d         = p_q;
    ridx_d      = ridx_q;
    ptr_d       = ptr_q;
    trained_d   = trained_q;
    last_d      = last_q;
    train_d     = train_q;
    sel_d       = sel_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    // Addresses
    cmd_o.scl_sel   = sel_q;
    cmd_o.mac_ring  = !train_q;
    cmd_o.coef_addr = k_q[laft_pkg::TAP_AW-1:0];
    cmd_o.ring_addr = (state_q == S_MOD) ? p_q : ridx_q;
    if (state_q == S_LOAD) begin
      cmd_o.des_addr = load_cnt_q[laft_pkg::ST_AW-1:0];
      cmd_o.ref_addr = load_cnt_q[laft_pkg::ST_AW-1:0];
    end else begin
      cmd_o.des_addr = i_q[laft_pkg::ST_AW-1:0];
      if (state_q inside {S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_UP_RD, S_UP_MUL, S_UP_WR}) begin
        cmd_o.ref_addr = laft_pkg::ST_AW'(i_q - laft_pkg::ST_CW'(k_q));
      end else begin
        cmd_o.ref_addr = i_q[laft_pkg::ST_AW-1:0];
      end
    end

    // Result taken by the receiver
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_latch = 1'b1;
          last_d         = in_item_i.last;
          state_d        = (in_item_i.mode == laft_pkg::MODE_RUN) ? S_RUN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (load_cnt_q < len) begin
          cmd_o.load_we = 1'b1;
          load_cnt_d    = load_cnt_q + laft_pkg::ST_CW'(1);
        end
        if (last_q) begin
          i_d            = '0;
          sel_d          = 1'b0;
          cmd_o.peak_clr = 1'b1;
          state_d        = S_PK_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (!trained_q) begin
          cmd_o.acc_clr = 1'b1;
          kind_d        = laft_pkg::KIND_FILTER;
          state_d       = S_DONE;
        end else begin
          p_d     = ptr_q;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // Reduce the ring pointer modulo the taps in use
        if (laft_pkg::TAP_CW'(p_q) >= taps) begin
          p_d = laft_pkg::TAP_AW'(laft_pkg::TAP_CW'(p_q) - taps);
        end else begin
          cmd_o.ring_we = 1'b1;
          cmd_o.acc_clr = 1'b1;
          k_d           = '0;
          ridx_d        = p_q;
          train_d       = 1'b0;
          state_d       = S_MAC_RD;
        end
      end
      S_MAC_RD: begin
        state_d = S_MAC_MUL;
      end
      S_MAC_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MAC_ACC;
      end
      S_MAC_ACC: begin
        cmd_o.acc_en = 1'b1;
        k_d          = k_inc;
        ridx_d       = (ridx_q == '0) ? laft_pkg::TAP_AW'(taps - laft_pkg::TAP_CW'(1))
                                      : ridx_q - laft_pkg::TAP_AW'(1);
        if (k_inc == taps) begin
          if (train_q) begin
            state_d = S_ERR;
          end else begin
            ptr_d   = (laft_pkg::TAP_CW'(p_inc) == taps) ? '0 : p_inc;
            kind_d  = laft_pkg::KIND_FILTER;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_MAC_RD;
        end
      end
      S_PK_RD: begin
        state_d = (i_q < len) ? S_PK_CMP : S_PK_END;
      end
      S_PK_CMP: begin
        cmd_o.peak_upd = 1'b1;
        i_d            = i_q + laft_pkg::ST_CW'(1);
        state_d        = S_PK_RD;
      end
      S_PK_END: begin
        i_d = '0;
        if (stat_i.peak_zero) begin
          if (!sel_q) begin
            sel_d          = 1'b1;
            cmd_o.peak_clr = 1'b1;
            state_d        = S_PK_RD;
          end else begin
            i_d     = laft_pkg::ST_CW'(taps);
            state_d = S_TR_I;
          end
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (i_q < len) begin
          state_d = S_SC_MUL;
        end else if (!sel_q) begin
          sel_d          = 1'b1;
          i_d            = '0;
          cmd_o.peak_clr = 1'b1;
          state_d        = S_PK_RD;
        end else begin
          i_d     = laft_pkg::ST_CW'(taps);
          state_d = S_TR_I;
        end
      end
      S_SC_MUL: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_SC_DIV;
      end
      S_SC_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + laft_pkg::STEP_CW'(1);
        if (step_q == laft_pkg::STEP_CW'(laft_pkg::QUO_W - 1)) begin
          state_d = S_SC_WR;
        end
      end
      S_SC_WR: begin
        cmd_o.scl_we = 1'b1;
        i_d          = i_q + laft_pkg::ST_CW'(1);
        state_d      = S_SC_RD;
      end
      S_TR_I: begin
        if (i_q < len) begin
          cmd_o.acc_clr = 1'b1;
          k_d           = '0;
          train_d       = 1'b1;
          state_d       = S_MAC_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ERR: begin
        cmd_o.err_en = 1'b1;
        state_d      = S_MUE;
      end
      S_MUE: begin
        cmd_o.mue_en = 1'b1;
        k_d          = '0;
        state_d      = S_UP_RD;
      end
      S_UP_RD: begin
        state_d = S_UP_MUL;
      end
      S_UP_MUL: begin
        cmd_o.dlt_en = 1'b1;
        state_d      = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.coef_we = 1'b1;
        k_d           = k_inc;
        if (k_inc == taps) begin
          i_d     = i_q + laft_pkg::ST_CW'(1);
          state_d = S_TR_I;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_FIN: begin
        cmd_o.ring_clr = 1'b1;
        ptr_d          = '0;
        load_cnt_d     = '0;
        trained_d      = 1'b1;
        kind_d         = laft_pkg::KIND_DONE;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      load_cnt_q  <= '0;
      k_q         <= '0;
      step_q      <= '0;
      p_q         <= '0;
      ridx_q      <= '0;
      ptr_q       <= '0;
      trained_q   <= 1'b0;
      last_q      <= 1'b0;
      train_q     <= 1'b0;
      sel_q       <= 1'b0;
      kind_q      <= laft_pkg::KIND_FILTER;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      load_cnt_q  <= load_cnt_d;
      k_q         <= k_d;
      step_q      <= step_d;
      p_q         <= p_d;
      ridx_q      <= ridx_d;
      ptr_q       <= ptr_d;
      trained_q   <= trained_d;
      last_q      <= last_d;
      train_q     <= train_d;
      sel_q       <= sel_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/lms_adaptive_fir_trainer.sv
// LMS adaptive FIR trainer: top level with configuration registers.
// Instantiates laft_ctrl and laft_dp; depends on laft_pkg.
//
// Usage: items enter on in_valid_i/in_stall_o/in_item_i. A load item
// (mode 0) stores one desired/reference pair if the store has room; the
// pair marked last starts learning and yields one item of kind 1. A run
// item (mode 1) filters one live sample and yields one item of kind 0.
// Results leave on out_valid_o/out_stall_i/out_item_o through an output
// register, so the next item is taken while a result still waits.
// Learning runs, for each store, a peak search and then, unless the store is
// all zero, a scaling pass through the divider; then the LMS pass, which
// uses the one shared MAC. A run item first folds the ring pointer into
// the taps in use after a tap count change.
// One item is in work at a time; in_stall_o is high while it runs.
// Reset clears coefficients and tap ring via valid bits and
// loads the register defaults. A stalled receiver holds the result; the
// block finishes the current item and then waits for the register to free.
// Configuration writes (cfg_valid_i, cfg_ready_o) are always taken.
`default_nettype none

module lms_adaptive_fir_trainer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire laft_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output laft_pkg::out_item_t                    out_item_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [laft_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [laft_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Configuration registers
  logic [laft_pkg::TAP_COUNT_W-1:0] tap_count_q;
  logic [laft_pkg::TRAIN_LEN_W-1:0] train_len_q;
  logic [laft_pkg::STEP_W-1:0]      step_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= laft_pkg::TAP_COUNT_RST;
      train_len_q <= laft_pkg::TRAIN_LEN_RST;
      step_size_q <= laft_pkg::STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        laft_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data_i[laft_pkg::TAP_COUNT_W-1:0];
        laft_pkg::REG_TRAIN_LEN: train_len_q <= cfg_data_i[laft_pkg::TRAIN_LEN_W-1:0];
        laft_pkg::REG_STEP_SIZE: step_size_q <= cfg_data_i[laft_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  laft_pkg::dp_cmd_t  cmd;
  laft_pkg::dp_stat_t stat;

  laft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tap_count_i (tap_count_q),
    .train_len_i (train_len_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  laft_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .step_size_i (step_size_q),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

  // An accepted item always makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after taking an item");

  // A new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // Scaling writes only happen for a store with a nonzero peak
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scl_we |-> !stat.peak_zero)
    else $error("scaling with zero peak");

endmodule

`default_nettype wire

>>> tb/sv/lms_adaptive_fir_trainer_tb.sv
// Self-checking testbench for lms_adaptive_fir_trainer: training blocks, live
// filtering and register changes, checked against an in-bench LMS predictor.
// Depends on laft_pkg and the lms_adaptive_fir_trainer RTL.
module lms_adaptive_fir_trainer_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  laft_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  laft_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [laft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [laft_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lms_adaptive_fir_trainer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: registers, coefficients, stores and tap ring
  int unsigned pr_taps = 32, pr_len = 4096, pr_mu = 328;
  int coef [laft_pkg::MAX_TAPS];
  shortint store [2][laft_pkg::MAX_TRAIN];   // 0 desired, 1 reference
  shortint ring [laft_pkg::MAX_TAPS];
  int unsigned ld_cnt = 0, rptr = 0;
  bit trained = 1'b0;

  laft_pkg::in_item_t pending_q[$];
  laft_pkg::out_item_t result_q[$];
  int n_mismatch = 0, n_results = 0, n_learn = 0, n_items = 0;
  bit no_idle = 1'b0;

  // Generator-side mirror of load_count and of the highest entry written
  int unsigned gen_cnt = 0, gen_hw = 0;

  function automatic int clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int unsigned taps_used();
    if (pr_taps < 1) return 1;
    if (pr_taps > laft_pkg::MAX_TAPS) return laft_pkg::MAX_TAPS;
    return pr_taps;
  endfunction

  function automatic int unsigned len_used();
    return (pr_len > laft_pkg::MAX_TRAIN) ? laft_pkg::MAX_TRAIN : pr_len;
  endfunction

  // Peak normalization followed by one LMS pass
  function automatic void lms_train();
    int unsigned t, n, peak, a;
    longint acc, err, d;
    t = taps_used();
    n = len_used();
    for (int s = 0; s < 2; s++) begin
      peak = 0;
      for (int i = 0; i < n; i++) begin
        a = (store[s][i] < 0) ? -int'(store[s][i]) : int'(store[s][i]);
        if (a > peak) peak = a;
      end
      if (peak != 0) begin
        for (int i = 0; i < n; i++) begin
          a = (store[s][i] < 0) ? -int'(store[s][i]) : int'(store[s][i]);
          a = (a * 32767) / peak;
          store[s][i] = (store[s][i] < 0) ? -shortint'(a) : shortint'(a);
        end
      end
    end
    for (int i = t; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < t; k++) acc += longint'(coef[k]) * store[1][i-k];
      err = longint'(store[0][i]) - clip16(acc >>> laft_pkg::COEF_FRAC);
      for (int k = 0; k < t; k++) begin
        d = longint'(pr_mu) * err * store[1][i-k];
        coef[k] = clip32(longint'(coef[k]) + (d >>> laft_pkg::DLT_SHIFT));
      end
    end
    foreach (ring[k]) ring[k] = 0;
    rptr = 0;
    ld_cnt = 0;
    trained = 1'b1;
  endfunction

  // Expected result of one accepted item, if any
  function automatic void predict(laft_pkg::in_item_t it);
    laft_pkg::out_item_t r;
    int unsigned t, p;
    longint acc;
    n_items++;
    if (it.mode == laft_pkg::MODE_LOAD) begin
      if (ld_cnt < len_used()) begin
        store[0][ld_cnt] = it.desired;
        store[1][ld_cnt] = it.reference;
        ld_cnt++;
      end
      if (!it.last) return;
      lms_train();
      n_learn++;
      r.kind = laft_pkg::KIND_DONE;
      r.filtered = '0;
    end else begin
      r.kind = laft_pkg::KIND_FILTER;
      r.filtered = '0;
      if (trained) begin
        t = taps_used();
        p = rptr % t;
        ring[p] = it.reference;
        acc = 0;
        for (int k = 0; k < t; k++) acc += longint'(coef[k]) * ring[(p + t - k) % t];
        rptr = (p + 1) % t;
        r.filtered = 16'(clip16(acc >>> laft_pkg::COEF_FRAC));
      end
    end
    result_q.push_back(r);
  endfunction

  // Driver: one item at a time from pending_q, random gap between items unless no_idle
  int gap_left = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict(in_item);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_item <= pending_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= no_idle ? 0 : $urandom_range(0, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result, then draw the stall before the next
  int stall_left = 0;
  always @(posedge clk or negedge rst_n) begin
    int n;
    laft_pkg::out_item_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result kind=%0d filtered=%0d",
                                       out_item.kind, out_item.filtered);
      end else begin
        e = result_q.pop_front();
        if (e.kind !== out_item.kind || e.filtered !== out_item.filtered) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected kind=%0d filtered=%0d, got kind=%0d filtered=%0d",
                     e.kind, e.filtered, out_item.kind, out_item.filtered);
        end
      end
      // long hold-off once, so the block backs up and stalls its input
      n = (n_results == 300) ? 500 : (no_idle ? 0 : $urandom_range(0, 18));
      stall_left <= n;
      out_stall <= (n > 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Wait until every item is in and every result out, and the bench stays quiet
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < 20) begin
      @(posedge clk);
      if (pending_q.size() != 0 || in_valid || result_q.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic write_cfg(laft_pkg::cfg_reg_e idx, int unsigned val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= laft_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      laft_pkg::REG_TAP_COUNT: pr_taps = val & 7'h7f;
      laft_pkg::REG_TRAIN_LEN: pr_len = val & 13'h1fff;
      default:                 pr_mu = val & 16'hffff;
    endcase
  endtask

  task automatic send(logic mode, int des, int refs, logic last);
    laft_pkg::in_item_t it;
    it.mode = mode;
    it.desired = 16'(des);
    it.reference = 16'(refs);
    it.last = last;
    pending_q.push_back(it);
    if (mode == laft_pkg::MODE_LOAD) begin
      if (gen_cnt < len_used()) gen_cnt++;
      if (gen_cnt > gen_hw) gen_hw = gen_cnt;
      if (last) gen_cnt = 0;
    end
  endtask

  function automatic int rnd_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return $signed($urandom_range(0, 255)) - 128;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Loads at least npairs pairs (last one marked), more if needed to never read unwritten entries
  task automatic train_block(int npairs, bit zero_des);
    int need;
    need = len_used() - gen_cnt;
    if (gen_hw < len_used() && npairs < need) npairs = need;
    if (npairs < 1) npairs = 1;
    for (int i = 0; i < npairs; i++)
      send(laft_pkg::MODE_LOAD, zero_des ? 0 : rnd_sample(), rnd_sample(),
           i == npairs - 1);
  endtask

  task automatic run_burst(int cnt);
    for (int i = 0; i < cnt; i++) begin
      // stray loads between runs: extra or partial pairs, no result
      if ($urandom_range(0, 19) == 0)
        send(laft_pkg::MODE_LOAD, rnd_sample(), rnd_sample(), 1'b0);
      else send(laft_pkg::MODE_RUN, rnd_sample(), rnd_sample(), $urandom_range(0, 1));
    end
  endtask

  initial begin
    int t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: runs before training, extremes of the fields
    send(laft_pkg::MODE_RUN, 32767, -32768, 1'b1);
    send(laft_pkg::MODE_RUN, -32768, 32767, 1'b0);
    send(laft_pkg::MODE_RUN, 0, 0, 1'b0);
    write_cfg(laft_pkg::REG_TAP_COUNT, 4);
    write_cfg(laft_pkg::REG_TRAIN_LEN, 10);
    write_cfg(laft_pkg::REG_STEP_SIZE, 65535);
    // all-zero desired store, then extreme runs
    train_block(10, 1'b1);
    send(laft_pkg::MODE_RUN, 0, 32767, 1'b0);
    send(laft_pkg::MODE_RUN, 0, -32768, 1'b0);
    // normal block with extra pairs past the length, then an early last
    for (int i = 0; i < 12; i++)
      send(laft_pkg::MODE_LOAD, (i & 1) ? 32767 : -32768, -32768 + i, 1'b0);
    send(laft_pkg::MODE_LOAD, 100, -100, 1'b1);
    send(laft_pkg::MODE_LOAD, 5, 7, 1'b1);
    run_burst(4);
    // tap count change after training folds the ring pointer
    write_cfg(laft_pkg::REG_TAP_COUNT, 3);
    run_burst(3);
    // length not above the tap count, then tap count 0 and above the maximum
    write_cfg(laft_pkg::REG_TRAIN_LEN, 2);
    write_cfg(laft_pkg::REG_TAP_COUNT, 2);
    train_block(2, 1'b0);
    write_cfg(laft_pkg::REG_TAP_COUNT, 0);
    run_burst(2);
    write_cfg(laft_pkg::REG_TAP_COUNT, 100);
    run_burst(2);

    // Long block back to back with one tap and no adaptation
    write_cfg(laft_pkg::REG_TAP_COUNT, 1);
    write_cfg(laft_pkg::REG_TRAIN_LEN, 400);
    write_cfg(laft_pkg::REG_STEP_SIZE, 0);
    no_idle = 1'b1;
    train_block(400, 1'b0);
    run_burst(40);
    drain();
    no_idle = 1'b0;

    // Full tap count with a short block
    write_cfg(laft_pkg::REG_TAP_COUNT, 64);
    write_cfg(laft_pkg::REG_TRAIN_LEN, 72);
    write_cfg(laft_pkg::REG_STEP_SIZE, $urandom_range(0, 65535));
    train_block(72, 1'b0);
    run_burst(60);

    // Random phases: new settings, a training block, then live samples
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 4 == 3);
      case ($urandom_range(0, 9))
        0: t = $urandom_range(0, 127);
        1: t = 64;
        default: t = $urandom_range(1, 8);
      endcase
      write_cfg(laft_pkg::REG_TAP_COUNT, t);
      if ($urandom_range(0, 5) == 0) write_cfg(laft_pkg::REG_TRAIN_LEN, $urandom_range(2, 8));
      else write_cfg(laft_pkg::REG_TRAIN_LEN, taps_used() + $urandom_range(1, 30));
      write_cfg(laft_pkg::REG_STEP_SIZE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                     : $urandom_range(0, 4000));
      for (int b = 0; b < 2; b++) begin
        train_block(len_used() - gen_cnt + (($urandom_range(0, 3) == 0) ? 3 : 0),
                    $urandom_range(0, 9) == 0);
        run_burst(taps_used() > 16 ? 20 : 60);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results, %0d training passes", n_items, n_results,
             n_learn);
    if (n_mismatch == 0 && result_q.size() == 0) begin
      $display("lms_adaptive_fir_trainer_tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, result_q.size());
      $display("lms_adaptive_fir_trainer_tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #12000000;
    $display("timeout");
    $display("lms_adaptive_fir_trainer_tb failed");
    $finish;
  end

endmodule

>>> lms_adaptive_fir_trainer.f
src/laft_pkg.sv
src/laft_dp.sv
src/laft_ctrl.sv
src/lms_adaptive_fir_trainer.sv
tb/sv/lms_adaptive_fir_trainer_tb.sv
